>>> design/hrhp_pkg.sv
// Types and constants for the HTTP request head parser.
package hrhp_pkg;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;

	localparam logic [3:0] LEN_SAT     = 4'd9;
	localparam logic [3:0] VERSION_LEN = 4'd8;
	localparam logic [3:0] GET_LEN     = 4'd3;
	localparam logic [3:0] POST_LEN    = 4'd4;
	localparam logic [3:0] VER_HEAD_LEN = 4'd7;

	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	typedef enum logic [1:0] {
		PH_REQUEST = 2'd0,
		PH_HEADERS = 2'd1,
		PH_BODY    = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		FLD_METHOD  = 2'd0,
		FLD_URL     = 2'd1,
		FLD_VERSION = 2'd2,
		FLD_TAIL    = 2'd3
	} field_t;

	typedef enum logic [2:0] {
		ROLE_METHOD  = 3'd0,
		ROLE_URL     = 3'd1,
		ROLE_VERSION = 3'd2,
		ROLE_KEY     = 3'd3,
		ROLE_VALUE   = 3'd4,
		ROLE_SEP     = 3'd5,
		ROLE_RAW     = 3'd6,
		ROLE_TERM    = 3'd7
	} role_t;

	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_REQ_OK = 3'd1,
		KIND_REQ_BAD = 3'd2,
		KIND_HEADER = 3'd3,
		KIND_END    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		METH_NONE = 2'd0,
		METH_GET  = 2'd1,
		METH_POST = 2'd2
	} meth_t;

	typedef enum logic [1:0] {
		VER_NONE = 2'd0,
		VER_10   = 2'd1,
		VER_11   = 2'd2
	} ver_t;

	// mcand bit 0: GET still possible, bit 1: POST still possible
	typedef struct packed {
		phase_t      phase;
		field_t      fidx;
		logic [3:0]  flen;
		logic [1:0]  mcand;
		logic        vpok;
		ver_t        vdig;
		logic        colon;
		logic        crp;
		logic        err;
	} pstate_t;

	typedef struct packed {
		logic [7:0] data;
		role_t      role;
		logic       line_end;
		kind_t      kind;
		meth_t      meth;
		ver_t       ver;
		logic       err;
		logic       last;
	} res_t;

	typedef struct packed {
		pstate_t st;
		res_t    r;
	} step_t;

endpackage

>>> design/http_request_head_parser.sv
// HTTP request head parser: byte classification, line splitting and result queue.
// Each result is written into the result queue when its byte is accepted.
// Throughput: one byte per cycle while the result port is not stalled and each byte
// gives at most one result; a byte giving two results (held CR resolved)
// queues both. A held CR gives no result until the next byte arrives.
// Reset clears parser state to the request-line phase and empties the result queue.
module http_request_head_parser
	import hrhp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [2:0] role,
	output logic       line_end,
	output logic [2:0] line_kind,
	output logic [1:0] method_code,
	output logic [1:0] version_code,
	output logic       error_seen,
	output logic       last
);

	function automatic logic [7:0] get_char(input logic [1:0] p);
		case (p)
			2'd0:    get_char = 8'h47;
			2'd1:    get_char = 8'h45;
			default: get_char = 8'h54;
		endcase
	endfunction

	function automatic logic [7:0] post_char(input logic [1:0] p);
		case (p)
			2'd0:    post_char = 8'h50;
			2'd1:    post_char = 8'h4F;
			2'd2:    post_char = 8'h53;
			default: post_char = 8'h54;
		endcase
	endfunction

	function automatic logic [7:0] ver_char(input logic [2:0] p);
		case (p)
			3'd0:    ver_char = 8'h48;
			3'd1:    ver_char = 8'h54;
			3'd2:    ver_char = 8'h54;
			3'd3:    ver_char = 8'h50;
			3'd4:    ver_char = 8'h2F;
			3'd5:    ver_char = 8'h31;
			default: ver_char = 8'h2E;
		endcase
	endfunction

	function automatic pstate_t line_reset(input pstate_t s);
		pstate_t n;
		n       = s;
		n.fidx  = FLD_METHOD;
		n.flen  = '0;
		n.mcand = 2'b11;
		n.vpok  = 1'b1;
		n.vdig  = VER_NONE;
		n.colon = 1'b0;
		return n;
	endfunction

	function automatic res_t mk_res(input logic [7:0] b, input role_t rl, input logic e);
		res_t r;
		r.data     = b;
		r.role     = rl;
		r.line_end = 1'b0;
		r.kind     = KIND_NONE;
		r.meth     = METH_NONE;
		r.ver      = VER_NONE;
		r.err      = e;
		r.last     = 1'b0;
		return r;
	endfunction

	function automatic step_t content(input pstate_t s, input logic [7:0] b);
		step_t      o;
		logic [3:0] p;
		logic [3:0] grown;
		p     = s.flen;
		grown = (s.flen < LEN_SAT) ? 4'(s.flen + 4'd1) : s.flen;
		o.st  = s;
		o.r   = mk_res(b, ROLE_RAW, s.err);
		if (s.phase == PH_REQUEST) begin
			case (s.fidx)
				FLD_METHOD: begin
					if (b == CH_SP) begin
						if (p != GET_LEN)  o.st.mcand[0] = 1'b0;
						if (p != POST_LEN) o.st.mcand[1] = 1'b0;
						o.st.fidx = FLD_URL;
						o.st.flen = '0;
						o.r.role  = ROLE_SEP;
					end else begin
						if (!(p < GET_LEN && b == get_char(p[1:0])))   o.st.mcand[0] = 1'b0;
						if (!(p < POST_LEN && b == post_char(p[1:0]))) o.st.mcand[1] = 1'b0;
						o.st.flen = grown;
						o.r.role  = ROLE_METHOD;
					end
				end
				FLD_URL: begin
					if (b == CH_SP) begin
						o.st.fidx = FLD_VERSION;
						o.st.flen = '0;
						o.st.vpok = 1'b1;
						o.st.vdig = VER_NONE;
						o.r.role  = ROLE_SEP;
					end else begin
						o.r.role  = ROLE_URL;
					end
				end
				FLD_VERSION: begin
					if (b == CH_SP) begin
						o.st.fidx = FLD_TAIL;
						o.r.role  = ROLE_SEP;
					end else begin
						if (p < VER_HEAD_LEN) begin
							if (b != ver_char(p[2:0])) o.st.vpok = 1'b0;
						end else if (p == VER_HEAD_LEN) begin
							o.st.vdig = (b == CH_ONE) ? VER_11 :
								(b == CH_ZERO) ? VER_10 : VER_NONE;
						end
						o.st.flen = grown;
						o.r.role  = ROLE_VERSION;
					end
				end
				default: o.r.role = ROLE_RAW;
			endcase
		end else if (s.phase == PH_HEADERS) begin
			if (!s.colon && b == CH_COLON) begin
				o.st.colon = 1'b1;
				o.r.role   = ROLE_SEP;
			end else begin
				o.r.role   = s.colon ? ROLE_VALUE : ROLE_KEY;
			end
		end
		return o;
	endfunction

	// closes a line: CR result from old state, LF result carries the verdict
	function automatic step_t end_line(input pstate_t s);
		step_t o;
		meth_t m;
		ver_t  v;
		logic  ver_ok;
		m      = METH_NONE;
		v      = VER_NONE;
		ver_ok = 1'b0;
		o.st   = s;
		o.r    = mk_res(CH_LF, ROLE_TERM, s.err);
		o.r.line_end = 1'b1;
		if (s.phase == PH_REQUEST) begin
			if (s.fidx != FLD_METHOD)
				m = s.mcand[0] ? METH_GET : (s.mcand[1] ? METH_POST : METH_NONE);
			ver_ok = (s.fidx == FLD_VERSION || s.fidx == FLD_TAIL) &&
				s.flen == VERSION_LEN && s.vpok;
			if (ver_ok)
				v = s.vdig;
			if (ver_ok && m != METH_NONE) begin
				o.r.kind   = KIND_REQ_OK;
				o.st.phase = PH_HEADERS;
			end else begin
				o.r.kind   = KIND_REQ_BAD;
				o.st.err   = 1'b1;
			end
		end else if (s.colon) begin
			o.r.kind   = KIND_HEADER;
		end else begin
			o.r.kind   = KIND_END;
			o.st.phase = PH_BODY;
		end
		o.r.meth = m;
		o.r.ver  = v;
		o.r.err  = o.st.err;
		o.st     = line_reset(o.st);
		return o;
	endfunction

	pstate_t st_q;
	pstate_t st_nx;
	res_t    r0;
	res_t    r1;
	logic [1:0] n_res;
	step_t   c_a;
	step_t   c_b;
	step_t   e_l;
	pstate_t s_clr;

	res_t             rq_q [RQ_DEPTH];
	logic [RQ_AW-1:0] wp_q;
	logic [RQ_AW-1:0] rp_q;
	logic [RQ_AW:0]   cnt_q;
	logic             acc;
	logic             pop;
	res_t             head;

	always_comb begin
		s_clr     = st_q;
		s_clr.crp = 1'b0;
		c_a   = content(s_clr, CH_CR);
		c_b   = content(st_q.crp ? c_a.st : st_q, data_byte);
		e_l   = end_line(s_clr);
		st_nx = st_q;
		r0    = mk_res(data_byte, ROLE_RAW, st_q.err);
		r1    = r0;
		n_res = 2'd0;
		if (st_q.phase != PH_REQUEST && st_q.phase != PH_HEADERS) begin
			n_res = 2'd1;
		end else if (st_q.crp) begin
			if (data_byte == CH_LF) begin
				r0    = mk_res(CH_CR, ROLE_TERM, st_q.err);
				r1    = e_l.r;
				st_nx = e_l.st;
				n_res = 2'd2;
			end else if (data_byte == CH_CR) begin
				r0     = c_a.r;
				st_nx  = c_a.st;
				st_nx.crp = 1'b1;
				n_res  = 2'd1;
			end else begin
				r0    = c_a.r;
				r1    = c_b.r;
				st_nx = c_b.st;
				n_res = 2'd2;
			end
		end else if (data_byte == CH_CR) begin
			st_nx.crp = 1'b1;
		end else begin
			r0    = c_b.r;
			st_nx = c_b.st;
			n_res = 2'd1;
		end
		if (n_res == 2'd1)
			r0.last = 1'b1;
		if (n_res == 2'd2)
			r1.last = 1'b1;
	end

	assign in_stall  = cnt_q > (RQ_AW+1)'(RQ_DEPTH - 2);
	assign acc       = in_valid && !in_stall;
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= line_reset('0);
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) begin
				st_q <= st_nx;
				wp_q <= RQ_AW'(wp_q + RQ_AW'(n_res));
			end
			if (pop)
				rp_q <= RQ_AW'(rp_q + 1'b1);
			cnt_q <= (RQ_AW+1)'(cnt_q + (acc ? (RQ_AW+1)'(n_res) : '0) -
				(RQ_AW+1)'(pop));
		end
	end

	always_ff @(posedge clk) begin
		if (acc && n_res != 2'd0)
			rq_q[wp_q] <= r0;
		if (acc && n_res == 2'd2)
			rq_q[RQ_AW'(wp_q + 1'b1)] <= r1;
	end

	assign head         = rq_q[rp_q];
	assign out_byte     = head.data;
	assign role         = head.role;
	assign line_end     = head.line_end;
	assign line_kind    = head.kind;
	assign method_code  = head.meth;
	assign version_code = head.ver;
	assign error_seen   = head.err;
	assign last         = head.last;

endmodule
